// ----- rtl/core/spf_pkg.sv -----
// shared constants, types and the arctangent table of the strand polyline block
package spf_pkg;

   localparam int COORD_FRAC_BITS = 16;
   localparam int ANGLE_BITS      = 16;
   localparam int CORDIC_STEPS    = 16;

   localparam int ATAN_ENTRIES = 24;
   localparam int ATAN_IDX_W   = 5;
   localparam int STEP_W       = $clog2(CORDIC_STEPS);

   // word operation and frame vector select codes
   localparam logic       OP_LOAD      = 1'b0;
   localparam logic       OP_SEGMENT   = 1'b1;
   localparam logic [1:0] SEL_ROOT     = 2'd0;
   localparam logic [1:0] SEL_NORMAL   = 2'd1;
   localparam logic [1:0] SEL_TANGENT  = 2'd2;
   localparam logic [1:0] SEL_BINORMAL = 2'd3;

   // phase keeps only the top angle bits of a 32-bit turn
   localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
   localparam logic [31:0] CORDIC_K   = 32'h26DD3B6A;

   // divider numerator is a 32-bit magnitude shifted up by the fraction bits
   localparam int NUM_W = 32 + COORD_FRAC_BITS;
   localparam int DIV_CNT_W = $clog2(NUM_W);

   // sine and cosine word from the rotation unit
   typedef struct packed {
      logic [31:0] sin_val;
      logic [31:0] cos_val;
   } sincos_type;

   // arctangent of 2^-i in 2^-32 turn
   function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:  v = 32'h20000000;
         5'd1:  v = 32'h12E4051E;
         5'd2:  v = 32'h09FB385B;
         5'd3:  v = 32'h051111D4;
         5'd4:  v = 32'h028B0D43;
         5'd5:  v = 32'h0145D7E1;
         5'd6:  v = 32'h00A2F61E;
         5'd7:  v = 32'h00517C55;
         5'd8:  v = 32'h0028BE53;
         5'd9:  v = 32'h00145F2F;
         5'd10: v = 32'h000A2F98;
         5'd11: v = 32'h000517CC;
         5'd12: v = 32'h00028BE6;
         5'd13: v = 32'h000145F3;
         5'd14: v = 32'h0000A2F9;
         5'd15: v = 32'h0000517C;
         5'd16: v = 32'h000028BE;
         5'd17: v = 32'h0000145F;
         5'd18: v = 32'h00000A2F;
         5'd19: v = 32'h00000517;
         5'd20: v = 32'h0000028B;
         5'd21: v = 32'h00000145;
         5'd22: v = 32'h000000A2;
         5'd23: v = 32'h00000051;
         default: v = 32'h00000000;
      endcase
      return v & PHASE_MASK;
   endfunction

endpackage

// ----- rtl/core/spf_cordic.sv -----
// iterative rotation unit giving Q30 sine and cosine of a binary angle
module spf_cordic (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [31:0]            phase,
   output logic                   done,
   output spf_pkg::sincos_type    result
);

   logic signed [32:0] x_ff, y_ff, z_ff;
   logic               flip_ff;
   logic               busy_ff, done_ff;
   logic [spf_pkg::STEP_W-1:0] cnt_ff;

   logic [31:0]        ph_m, ph_r;
   logic               flip;
   logic signed [32:0] dx, dy, ang;
   logic signed [32:0] sin_w, cos_w;

   // fold the left half plane onto the right one
   always_comb begin
      ph_m = phase & spf_pkg::PHASE_MASK;
      flip = (ph_m[31:30] == 2'd1) || (ph_m[31:30] == 2'd2);
      ph_r = flip ? (ph_m + 32'h80000000) : ph_m;
   end

   // one rotation step
   always_comb begin
      dx  = y_ff >>> cnt_ff;
      dy  = x_ff >>> cnt_ff;
      ang = {1'b0, spf_pkg::atan_turn(spf_pkg::ATAN_IDX_W'(cnt_ff))};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            x_ff    <= {1'b0, spf_pkg::CORDIC_K};
            y_ff    <= '0;
            z_ff    <= {ph_r[31], ph_r};
            flip_ff <= flip;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            if (!z_ff[32]) begin
               x_ff <= x_ff - dx;
               y_ff <= y_ff + dy;
               z_ff <= z_ff - ang;
            end else begin
               x_ff <= x_ff + dx;
               y_ff <= y_ff - dy;
               z_ff <= z_ff + ang;
            end
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == spf_pkg::STEP_W'(spf_pkg::CORDIC_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // undo the fold
   assign sin_w = flip_ff ? -y_ff : y_ff;
   assign cos_w = flip_ff ? -x_ff : x_ff;
   assign result.sin_val = sin_w[31:0];
   assign result.cos_val = cos_w[31:0];
   assign done = done_ff;

endmodule

// ----- rtl/core/spf_sqrt.sv -----
// bit-pair integer square root of a 64-bit sum of squares
module spf_sqrt (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] radicand,
   output logic        done,
   output logic [31:0] root
);

   logic [63:0] s_ff, root_ff, bit_ff;
   logic [4:0]  cnt_ff;
   logic        busy_ff, done_ff;
   logic [63:0] trial;

   assign trial = root_ff + bit_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            s_ff    <= radicand;
            root_ff <= '0;
            bit_ff  <= 64'd1 << 62;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            // one result bit a cycle
            if (s_ff >= trial) begin
               s_ff    <= s_ff - trial;
               root_ff <= (root_ff >> 1) + bit_ff;
            end else begin
               root_ff <= root_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == 5'd31) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign root = root_ff[31:0];
   assign done = done_ff;

endmodule

// ----- rtl/core/spf_div.sv -----
// restoring divider, one quotient bit a cycle
module spf_div (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [spf_pkg::NUM_W-1:0] numer,
   input  logic [31:0]              denom,
   output logic                     done,
   output logic [31:0]              quot
);

   logic [32:0]               rem_ff;
   logic [spf_pkg::NUM_W-1:0] quo_ff;
   logic [31:0]               den_ff;
   logic [spf_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                      busy_ff, done_ff;
   logic [32:0]               trial;
   logic                      ge;

   always_comb begin
      trial = {rem_ff[31:0], quo_ff[spf_pkg::NUM_W-1]};
      ge    = trial >= {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= '0;
            quo_ff  <= numer;
            den_ff  <= denom;
            cnt_ff  <= '0;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= ge ? (trial - {1'b0, den_ff}) : trial;
            quo_ff <= {quo_ff[spf_pkg::NUM_W-2:0], ge};
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == spf_pkg::DIV_CNT_W'(spf_pkg::NUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign quot = quo_ff[31:0];
   assign done = done_ff;

endmodule

// ----- rtl/core/strand_polyline_from_spherical.sv -----
// strand polyline rebuild: sequencer, shared multiplier and frame state
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | operation, select, vector, angles, length
//  rsp     | out       | rsp_valid/rsp_stall | point xyz, is_root, strand_end
//
// a root load goes from the idle state through the emit state into the output register
// a normal, tangent or binormal load is normalized; a segment is rotated, then normalized;
//   the three restoring divisions of the normalization take up most of the time of both
// each segment needs a sine and cosine pair per angle, each normalization a square root
// reset clears the current point and the frame to zero; no clearing pass
// one result register: a new word is taken while a finished point waits
module strand_polyline_from_spherical (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_operation,
   input  logic [1:0]         req_vector_select,
   input  logic signed [31:0] req_vec_x,
   input  logic signed [31:0] req_vec_y,
   input  logic signed [31:0] req_vec_z,
   input  logic [14:0]        req_inclination,
   input  logic signed [15:0] req_azimuth,
   input  logic [30:0]        req_seg_length,
   input  logic               req_last_segment,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_point_x,
   output logic signed [31:0] rsp_point_y,
   output logic signed [31:0] rsp_point_z,
   output logic               rsp_is_root,
   output logic               rsp_strand_end
);

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_EMIT      = 4'd1;
   localparam logic [3:0] ST_CORD_GO   = 4'd2;
   localparam logic [3:0] ST_CORD_WAIT = 4'd3;
   localparam logic [3:0] ST_TRIG_MUL  = 4'd4;
   localparam logic [3:0] ST_TRIG_ACC  = 4'd5;
   localparam logic [3:0] ST_DIR_MUL   = 4'd6;
   localparam logic [3:0] ST_DIR_ACC   = 4'd7;
   localparam logic [3:0] ST_SQ_MUL    = 4'd8;
   localparam logic [3:0] ST_SQ_ACC    = 4'd9;
   localparam logic [3:0] ST_SQRT_GO   = 4'd10;
   localparam logic [3:0] ST_SQRT_WAIT = 4'd11;
   localparam logic [3:0] ST_DIV_GO    = 4'd12;
   localparam logic [3:0] ST_DIV_WAIT  = 4'd13;
   localparam logic [3:0] ST_STEP_MUL  = 4'd14;
   localparam logic [3:0] ST_STEP_ACC  = 4'd15;

   localparam int FB = spf_pkg::COORD_FRAC_BITS;
   localparam logic signed [65:0] ROUND = 66'sd1 <<< (FB - 1);

   // control
   logic [3:0] state_ff;
   logic [1:0] k_ff, j_ff;
   logic       root_ff;

   // latched word
   logic        seg_ff, last_ff;
   logic [1:0]  sel_ff;
   logic [30:0] len_ff;
   logic [14:0] inc_ff;
   logic [15:0] az_ff;

   // state and working values
   logic signed [31:0] point_ff [3];
   logic signed [31:0] frame_ff [3][3];
   logic signed [31:0] nv_ff [3];
   logic signed [31:0] u_ff [3];
   logic [31:0]        nlen_ff;
   logic signed [31:0] si_ff, ci_ff, sa_ff, ca_ff, ss_ff, sc_ff;
   logic signed [65:0] prod_ff, acc_ff;

   // result register
   logic               rsp_valid_ff, rsp_root_ff, rsp_end_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff;
   logic               emit_go;

   // unit hookups
   logic               cord_start, cord_done;
   logic [31:0]        cord_phase;
   spf_pkg::sincos_type cord_res;
   logic               sq_start, sq_done;
   logic [31:0]        sq_root;
   logic               div_start, div_done;
   logic [31:0]        div_q;

   logic signed [32:0] op_a, op_b;
   logic [31:0]        mag_k;
   logic signed [31:0] coef;
   logic signed [65:0] acc_sum, dir_d, step_sum;
   logic [31:0]        u_val;
   logic [1:0]         fsel;

   spf_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cord_start),
      .phase  (cord_phase),
      .done   (cord_done),
      .result (cord_res)
   );

   spf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (acc_ff[63:0]),
      .done     (sq_done),
      .root     (sq_root)
   );

   spf_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .numer ({mag_k, {FB{1'b0}}}),
      .denom (nlen_ff),
      .done  (div_done),
      .quot  (div_q)
   );

   // unit starts and operand selection
   always_comb begin
      cord_start = state_ff == ST_CORD_GO;
      sq_start   = state_ff == ST_SQRT_GO;
      div_start  = state_ff == ST_DIV_GO;
      emit_go    = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);
      cord_phase = (j_ff == 2'd0) ? {1'b0, inc_ff, 16'd0} : {az_ff, 16'd0};
      mag_k      = nv_ff[k_ff][31] ? 32'(-nv_ff[k_ff]) : nv_ff[k_ff];
      fsel       = sel_ff - spf_pkg::SEL_NORMAL;
      unique case (j_ff)
         2'd0:    coef = ci_ff;
         2'd1:    coef = sc_ff;
         default: coef = ss_ff;
      endcase
   end

   // shared multiplier inputs
   always_comb begin
      unique case (state_ff)
         ST_SQ_MUL: begin
            op_a = {1'b0, mag_k};
            op_b = {1'b0, mag_k};
         end
         ST_TRIG_MUL: begin
            op_a = 33'(si_ff);
            op_b = (j_ff == 2'd0) ? 33'(sa_ff) : 33'(ca_ff);
         end
         ST_DIR_MUL: begin
            op_a = 33'(frame_ff[j_ff][k_ff]);
            op_b = 33'(coef);
         end
         ST_STEP_MUL: begin
            op_a = 33'(u_ff[k_ff]);
            op_b = {2'b00, len_ff};
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   // sums after the multiplier
   always_comb begin
      acc_sum  = acc_ff + prod_ff;
      dir_d    = acc_sum >>> 30;
      step_sum = (prod_ff + ROUND) >>> FB;
      if (nlen_ff == 32'd0) begin
         u_val = 32'd0;
      end else begin
         u_val = nv_ff[k_ff][31] ? -div_q : div_q;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

   // result valid: set on emit, cleared when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         k_ff         <= '0;
         j_ff         <= '0;
         root_ff      <= 1'b0;
         for (int a = 0; a < 3; a++) begin
            point_ff[a] <= '0;
            for (int b = 0; b < 3; b++) begin
               frame_ff[a][b] <= '0;
            end
         end
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  seg_ff  <= req_operation;
                  sel_ff  <= req_vector_select;
                  len_ff  <= req_seg_length;
                  inc_ff  <= req_inclination;
                  az_ff   <= req_azimuth;
                  last_ff <= req_last_segment;
                  k_ff    <= '0;
                  j_ff    <= '0;
                  acc_ff  <= '0;
                  if (req_operation == spf_pkg::OP_SEGMENT) begin
                     root_ff  <= 1'b0;
                     state_ff <= ST_CORD_GO;
                  end else if (req_vector_select == spf_pkg::SEL_ROOT) begin
                     point_ff[0] <= req_vec_x;
                     point_ff[1] <= req_vec_y;
                     point_ff[2] <= req_vec_z;
                     root_ff     <= 1'b1;
                     state_ff    <= ST_EMIT;
                  end else begin
                     nv_ff[0] <= req_vec_x;
                     nv_ff[1] <= req_vec_y;
                     nv_ff[2] <= req_vec_z;
                     state_ff <= ST_SQ_MUL;
                  end
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_x_ff     <= point_ff[0];
                  rsp_y_ff     <= point_ff[1];
                  rsp_z_ff     <= point_ff[2];
                  rsp_root_ff  <= root_ff;
                  rsp_end_ff   <= seg_ff & last_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_CORD_GO: begin
               state_ff <= ST_CORD_WAIT;
            end
            ST_CORD_WAIT: begin
               if (cord_done) begin
                  if (j_ff == 2'd0) begin
                     si_ff    <= cord_res.sin_val;
                     ci_ff    <= cord_res.cos_val;
                     j_ff     <= 2'd1;
                     state_ff <= ST_CORD_GO;
                  end else begin
                     sa_ff    <= cord_res.sin_val;
                     ca_ff    <= cord_res.cos_val;
                     j_ff     <= 2'd0;
                     state_ff <= ST_TRIG_MUL;
                  end
               end
            end
            ST_TRIG_MUL: begin
               state_ff <= ST_TRIG_ACC;
            end
            ST_TRIG_ACC: begin
               // sin(inc) times sin and cos of azimuth, back to Q30
               if (j_ff == 2'd0) begin
                  ss_ff    <= prod_ff[61:30];
                  j_ff     <= 2'd1;
                  state_ff <= ST_TRIG_MUL;
               end else begin
                  sc_ff    <= prod_ff[61:30];
                  j_ff     <= 2'd0;
                  k_ff     <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= ST_DIR_MUL;
               end
            end
            ST_DIR_MUL: begin
               state_ff <= ST_DIR_ACC;
            end
            ST_DIR_ACC: begin
               // direction component: three products per axis
               if (j_ff == 2'd2) begin
                  nv_ff[k_ff] <= dir_d[31:0];
                  acc_ff      <= '0;
                  j_ff        <= 2'd0;
                  if (k_ff == 2'd2) begin
                     k_ff     <= 2'd0;
                     state_ff <= ST_SQ_MUL;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= ST_DIR_MUL;
                  end
               end else begin
                  acc_ff   <= acc_sum;
                  j_ff     <= j_ff + 2'd1;
                  state_ff <= ST_DIR_MUL;
               end
            end
            ST_SQ_MUL: begin
               state_ff <= ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
               acc_ff <= acc_sum;
               if (k_ff == 2'd2) begin
                  state_ff <= ST_SQRT_GO;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_SQ_MUL;
               end
            end
            ST_SQRT_GO: begin
               state_ff <= ST_SQRT_WAIT;
            end
            ST_SQRT_WAIT: begin
               if (sq_done) begin
                  nlen_ff  <= sq_root;
                  k_ff     <= 2'd0;
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_DIV_GO: begin
               state_ff <= ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
               if (div_done) begin
                  if (seg_ff) begin
                     u_ff[k_ff] <= u_val;
                  end else begin
                     frame_ff[fsel][k_ff] <= u_val;
                  end
                  if (k_ff == 2'd2) begin
                     k_ff     <= 2'd0;
                     state_ff <= seg_ff ? ST_STEP_MUL : ST_IDLE;
                  end else begin
                     k_ff     <= k_ff + 2'd1;
                     state_ff <= ST_DIV_GO;
                  end
               end
            end
            ST_STEP_MUL: begin
               state_ff <= ST_STEP_ACC;
            end
            ST_STEP_ACC: begin
               // rounded step added with wrap
               point_ff[k_ff] <= point_ff[k_ff] + step_sum[31:0];
               if (k_ff == 2'd2) begin
                  state_ff <= ST_EMIT;
               end else begin
                  k_ff     <= k_ff + 2'd1;
                  state_ff <= ST_STEP_MUL;
               end
            end
         endcase
      end
   end

   assign req_stall      = state_ff != ST_IDLE;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_point_x    = rsp_x_ff;
   assign rsp_point_y    = rsp_y_ff;
   assign rsp_point_z    = rsp_z_ff;
   assign rsp_is_root    = rsp_root_ff;
   assign rsp_strand_end = rsp_end_ff;

`ifndef SYNTH
   // a root load goes straight to the output stage
   a_root_emit: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_operation == spf_pkg::OP_LOAD
       && req_vector_select == spf_pkg::SEL_ROOT)
      |=> state_ff == ST_EMIT)
      else $error("root load did not go to emit");

   // an empty result register is filled on the emit cycle
   a_emit_fill: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !rsp_valid_ff) |=> rsp_valid_ff)
      else $error("emit did not fill result register");

   // unit completions only land while the sequencer waits for them
   a_sqrt_done: assert property (@(posedge clock) disable iff (reset)
      sq_done |-> state_ff == ST_SQRT_WAIT)
      else $error("square root done out of sequence");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV_WAIT)
      else $error("divide done out of sequence");

   a_cord_done: assert property (@(posedge clock) disable iff (reset)
      cord_done |-> state_ff == ST_CORD_WAIT)
      else $error("rotation done out of sequence");
`endif

endmodule

// ----- sim/tb_strand_polyline_from_spherical.sv -----
// testbench for the strand polyline rebuild block with a self-contained point predictor
module tb_strand_polyline_from_spherical;

   localparam int CLK_HALF  = 6;
   localparam int DRAIN_CYC = 400;

   typedef struct {
      logic signed [31:0] x, y, z;
      logic               is_root;
      logic               strand_end;
   } point_type;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic               req_operation;
   logic [1:0]         req_vector_select;
   logic signed [31:0] req_vec_x, req_vec_y, req_vec_z;
   logic [14:0]        req_inclination;
   logic signed [15:0] req_azimuth;
   logic [30:0]        req_seg_length;
   logic               req_last_segment;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_point_x, rsp_point_y, rsp_point_z;
   logic               rsp_is_root;
   logic               rsp_strand_end;

   // predictor state
   longint cur_pt [3];
   longint nrm [3];
   longint tan [3];
   longint bin [3];
   point_type expected_points [$];
   int     failures = 0;
   bit     calm = 0;

   logic [31:0] arctan_turns [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C, 32'h000028BE, 32'h0000145F,
      32'h00000A2F, 32'h00000517, 32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051};

   strand_polyline_from_spherical u_top (.*);

   // clock
   always begin
      clock = 1'b1;
      #CLK_HALF;
      clock = 1'b0;
      #CLK_HALF;
   end

   // integer square root, floor
   function automatic longint unsigned int_sqrt(input longint unsigned s);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > s) bitv >>= 2;
      while (bitv != 0) begin
         if (s >= root + bitv) begin
            s -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   // scale a vector to unit length in Q2.F
   function automatic void unit_vector(input longint c [3], output longint u [3]);
      longint unsigned mag [3];
      longint unsigned sum, len, q;
      sum = 0;
      for (int k = 0; k < 3; k++) begin
         mag[k] = (c[k] < 0) ? longint'(-c[k]) : c[k];
         sum += mag[k] * mag[k];
      end
      len = int_sqrt(sum);
      for (int k = 0; k < 3; k++) begin
         q = (len == 0) ? 0 : (mag[k] << spf_pkg::COORD_FRAC_BITS) / len;
         u[k] = (c[k] < 0) ? -longint'(q) : longint'(q);
      end
   endfunction

   // rotation-based sine and cosine in Q30
   function automatic void sine_cosine(input logic [31:0] phase, output longint s,
                                       output longint c);
      longint x, y, z, dx, dy, a;
      bit     flip;
      x = longint'(spf_pkg::CORDIC_K);
      y = 0;
      phase &= spf_pkg::PHASE_MASK;
      flip = (phase[31:30] == 2'd1) || (phase[31:30] == 2'd2);
      if (flip) phase += 32'h80000000;
      z = longint'(signed'(phase));
      for (int i = 0; i < spf_pkg::CORDIC_STEPS && i < 24; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         a  = longint'({32'd0, arctan_turns[i] & spf_pkg::PHASE_MASK});
         if (z >= 0) begin
            x -= dx; y += dy; z -= a;
         end else begin
            x += dx; y -= dy; z += a;
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   // expected point for one accepted word
   task automatic predict_point(input bit op, input logic [1:0] sel,
                                input logic signed [31:0] vx, vy, vz,
                                input logic [14:0] inc, input logic signed [15:0] az,
                                input logic [30:0] len, input bit last);
      longint v [3];
      longint u [3];
      longint d [3];
      longint si, ci, sa, ca, ss, sc, acc, stp;
      logic [31:0] sum [3];
      point_type p;
      v = '{longint'(vx), longint'(vy), longint'(vz)};
      if (op == spf_pkg::OP_LOAD) begin
         if (sel == spf_pkg::SEL_ROOT) begin
            cur_pt = v;
            p = '{vx, vy, vz, 1'b1, 1'b0};
            expected_points.push_back(p);
         end else begin
            unit_vector(v, u);
            case (sel)
               spf_pkg::SEL_NORMAL:  nrm = u;
               spf_pkg::SEL_TANGENT: tan = u;
               default:              bin = u;
            endcase
         end
      end else begin
         sine_cosine({1'b0, inc, 16'd0}, si, ci);
         sine_cosine({az, 16'd0}, sa, ca);
         ss = (si * sa) >>> 30;
         sc = (si * ca) >>> 30;
         for (int k = 0; k < 3; k++) begin
            acc  = nrm[k] * ci + bin[k] * ss + tan[k] * sc;
            d[k] = acc >>> 30;
         end
         unit_vector(d, u);
         for (int k = 0; k < 3; k++) begin
            stp = (u[k] * longint'(len) + (64'sd1 <<< (spf_pkg::COORD_FRAC_BITS - 1)))
                  >>> spf_pkg::COORD_FRAC_BITS;
            sum[k] = 32'(cur_pt[k] + stp);
            cur_pt[k] = longint'(signed'(sum[k]));
         end
         p = '{sum[0], sum[1], sum[2], 1'b0, last};
         expected_points.push_back(p);
      end
   endtask

   // send one word and wait for it to be taken
   task automatic send_word(input bit op, input logic [1:0] sel,
                            input logic signed [31:0] vx, vy, vz,
                            input logic [14:0] inc, input logic signed [15:0] az,
                            input logic [30:0] len, input bit last);
      bit st;
      if (!calm && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_vector_select <= sel;
      req_vec_x         <= vx;
      req_vec_y         <= vy;
      req_vec_z         <= vz;
      req_inclination   <= inc;
      req_azimuth       <= az;
      req_seg_length    <= len;
      req_last_segment  <= last;
      forever begin
         @(negedge clock);
         st = req_stall;
         @(posedge clock);
         if (!st) break;
      end
      predict_point(op, sel, vx, vy, vz, inc, az, len, last);
   endtask

   task automatic load_vec(input logic [1:0] sel, input logic signed [31:0] vx, vy, vz);
      send_word(spf_pkg::OP_LOAD, sel, vx, vy, vz, 15'($urandom), 16'($urandom),
                31'($urandom), 1'($urandom));
   endtask

   task automatic segment(input logic [14:0] inc, input logic signed [15:0] az,
                          input logic [30:0] len, input bit last);
      send_word(spf_pkg::OP_SEGMENT, 2'($urandom), $urandom, $urandom, $urandom, inc, az,
                len, last);
   endtask

   function automatic logic [31:0] rand_coord();
      int r;
      r = $urandom_range(99);
      if (r < 50) return 32'($signed($urandom_range(0, 32'h40000)) - 32'sh20000);
      if (r < 80) return $urandom;
      return (r < 90) ? 32'sh10000 : 32'sh0;
   endfunction

   function automatic logic [30:0] rand_length();
      return ($urandom_range(99) < 85) ? 31'($urandom_range(0, 32'h80000)) : 31'($urandom);
   endfunction

   // response side: random stall, check in the cycle of acceptance
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else rsp_stall <= !calm && ($urandom_range(99) < 12);
   end

   always @(negedge clock) begin
      point_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_points.size() == 0) begin
            $error("unexpected point %h %h %h", rsp_point_x, rsp_point_y, rsp_point_z);
            failures++;
         end else begin
            e = expected_points.pop_front();
            if (rsp_point_x !== e.x) begin
               $error("point_x expected %h got %h", e.x, rsp_point_x); failures++;
            end
            if (rsp_point_y !== e.y) begin
               $error("point_y expected %h got %h", e.y, rsp_point_y); failures++;
            end
            if (rsp_point_z !== e.z) begin
               $error("point_z expected %h got %h", e.z, rsp_point_z); failures++;
            end
            if (rsp_is_root !== e.is_root) begin
               $error("is_root expected %b got %b", e.is_root, rsp_is_root); failures++;
            end
            if (rsp_strand_end !== e.strand_end) begin
               $error("strand_end expected %b got %b", e.strand_end, rsp_strand_end);
               failures++;
            end
         end
      end
   end

   // segments on the reset frame: degenerate direction, point repeats
   task automatic test_reset_frame();
      segment(15'd0, 16'sd0, 31'h7FFFFFFF, 1'b0);
      segment(15'd12345, -16'sd300, 31'h10000, 1'b1);
   endtask

   // field extremes, zero vectors and wrapping
   task automatic test_extremes();
      load_vec(spf_pkg::SEL_ROOT, 32'sh7FFFFFFF, 32'sh80000000, 32'sh0);
      load_vec(spf_pkg::SEL_NORMAL, 32'sh0, 32'sh0, 32'sh80000000);
      load_vec(spf_pkg::SEL_TANGENT, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF);
      load_vec(spf_pkg::SEL_BINORMAL, 32'sh0, 32'sh0, 32'sh0);
      segment(15'd0, 16'sh8000, 31'h7FFFFFFF, 1'b0);
      segment(15'h7FFF, 16'sh7FFF, 31'h7FFFFFFF, 1'b0);
      segment(15'h4000, 16'sh8000, 31'd0, 1'b0);
      segment(15'h4000, 16'sh4000, 31'h7FFFFFFF, 1'b0);
      load_vec(spf_pkg::SEL_NORMAL, 32'sh0, 32'sh0, 32'sh0);
      segment(15'd100, 16'sh4000, 31'h10000, 1'b0);
      load_vec(spf_pkg::SEL_BINORMAL, 32'sh7FFFFFFF, 32'shFFFFFFFF, 32'sh1);
      segment(15'h2000, -16'sh2000, 31'h12345, 1'b1);
      load_vec(spf_pkg::SEL_ROOT, 32'sh0, 32'sh0, 32'sh0);
      load_vec(spf_pkg::SEL_NORMAL, 32'sh0, 32'sh10000, 32'sh0);
      load_vec(spf_pkg::SEL_TANGENT, 32'sh10000, 32'sh0, 32'sh0);
      load_vec(spf_pkg::SEL_BINORMAL, 32'sh0, 32'sh0, 32'sh10000);
      segment(15'd0, 16'sd0, 31'h10000, 1'b0);
      segment(15'h7FFF, 16'sd0, 31'h10000, 1'b1);
   endtask

   // whole strands with random content plus stray words
   task automatic test_random_strands(input int n_items);
      int sent, nseg;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(99) < 15) begin
            send_word(1'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                      15'($urandom), 16'($urandom), rand_length(), 1'($urandom));
            sent++;
         end else begin
            load_vec(spf_pkg::SEL_ROOT, rand_coord(), rand_coord(), rand_coord());
            if ($urandom_range(99) < 80) begin
               load_vec(spf_pkg::SEL_NORMAL, rand_coord(), rand_coord(), rand_coord());
               load_vec(spf_pkg::SEL_TANGENT, rand_coord(), rand_coord(), rand_coord());
               load_vec(spf_pkg::SEL_BINORMAL, rand_coord(), rand_coord(), rand_coord());
               sent += 3;
            end
            nseg = $urandom_range(1, 8);
            for (int i = 0; i < nseg; i++)
               segment(15'($urandom), 16'($urandom), rand_length(), i == nseg - 1);
            sent += nseg + 1;
         end
      end
   endtask

   // back-to-back traffic with no idling on either side
   task automatic test_back_to_back();
      calm = 1'b1;
      test_random_strands(60);
      calm = 1'b0;
   endtask

   initial begin
      reset             <= 1'b1;
      req_valid         <= 1'b0;
      req_operation     <= 1'b0;
      req_vector_select <= '0;
      req_vec_x         <= '0;
      req_vec_y         <= '0;
      req_vec_z         <= '0;
      req_inclination   <= '0;
      req_azimuth       <= '0;
      req_seg_length    <= '0;
      req_last_segment  <= 1'b0;
      for (int k = 0; k < 3; k++) begin
         cur_pt[k] = 0; nrm[k] = 0; tan[k] = 0; bin[k] = 0;
      end
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_frame();
      test_extremes();
      test_random_strands(370);
      test_back_to_back();
      test_random_strands(370);
      req_valid <= 1'b0;
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_CYC) @(posedge clock);
      if (failures == 0 && expected_points.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   // run limit
   initial begin
      #(2 * CLK_HALF * 3000000);
      $display("Test completed with failures");
      $finish;
   end

endmodule
